// ===== sv/drgc_pkg.sv =====
// shared constants and types for the defect rectangle to grid cell block
// no dependencies
package drgc_pkg;

    localparam int SIZE_W      = 23;
    localparam int COUNT_W     = 7;
    localparam int TAG_W       = 16;
    localparam int MAX_CELLS_D = 64;
    localparam int COORD_D     = 24;
    localparam int NPTS        = 5;
    localparam int SEEN_N      = NPTS - 1;

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(16000);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

    // config register index
    typedef enum logic [1:0] {
        REG_SURF_W = 2'd0,
        REG_SURF_H = 2'd1,
        REG_COLS   = 2'd2,
        REG_ROWS   = 2'd3
    } t_reg;

    // tested point, in emission order
    typedef enum logic [2:0] {
        PT_TL  = 3'd0,
        PT_TR  = 3'd1,
        PT_BL  = 3'd2,
        PT_BR  = 3'd3,
        PT_MID = 3'd4
    } t_pt;

    // sideband that follows a point through the divider
    typedef struct packed {
        logic           vld;
        t_pt            idx;
        logic [TAG_W-1:0] tag;
    } t_side;

endpackage

// ===== sv/drgc_point_gen.sv =====
// point sequencer: holds one defect and forms its five test points
// depends on drgc_pkg
module drgc_point_gen #(
    parameter int COORD_BITS = drgc_pkg::COORD_D
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [COORD_BITS-1:0]  i_x,
    input  logic signed [COORD_BITS-1:0]  i_y,
    input  logic signed [COORD_BITS-1:0]  i_w,
    input  logic signed [COORD_BITS-1:0]  i_h,
    input  logic [drgc_pkg::TAG_W-1:0]    i_tag,
    output logic                          o_busy,
    output logic signed [COORD_BITS:0]    o_px,
    output logic signed [COORD_BITS:0]    o_py,
    output drgc_pkg::t_side               o_side
);

    logic signed [COORD_BITS-1:0] r_x, r_y, r_w, r_h;
    logic [drgc_pkg::TAG_W-1:0]   r_tag;
    logic                         r_act;
    drgc_pkg::t_pt                r_idx;
    logic                         accept;
    logic signed [COORD_BITS:0]   ex, ey, ew, eh, n_px, n_py;
    logic signed [COORD_BITS:0]   r_px, r_py;
    drgc_pkg::t_side              r_side;

    assign o_busy = r_act && (r_idx != drgc_pkg::PT_MID);
    assign accept = i_start && !o_busy;

    // defect hold and point counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_idx <= drgc_pkg::PT_TL;
        end else if (accept) begin
            r_act <= 1'b1;
            r_idx <= drgc_pkg::PT_TL;
        end else if (r_act) begin
            case (r_idx)
                drgc_pkg::PT_TL:  r_idx <= drgc_pkg::PT_TR;
                drgc_pkg::PT_TR:  r_idx <= drgc_pkg::PT_BL;
                drgc_pkg::PT_BL:  r_idx <= drgc_pkg::PT_BR;
                drgc_pkg::PT_BR:  r_idx <= drgc_pkg::PT_MID;
                default:          r_act <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_w   <= i_w;
            r_h   <= i_h;
            r_tag <= i_tag;
        end
    end

    // point coordinates, one bit wider so sums never wrap
    always_comb begin
        ex = {r_x[COORD_BITS-1], r_x};
        ey = {r_y[COORD_BITS-1], r_y};
        ew = {r_w[COORD_BITS-1], r_w};
        eh = {r_h[COORD_BITS-1], r_h};
        case (r_idx)
            drgc_pkg::PT_TL: begin n_px = ex;      n_py = ey;      end
            drgc_pkg::PT_TR: begin n_px = ex + ew; n_py = ey;      end
            drgc_pkg::PT_BL: begin n_px = ex;      n_py = ey + eh; end
            drgc_pkg::PT_BR: begin n_px = ex + ew; n_py = ey + eh; end
            default: begin
                n_px = ex + (ew >>> 1);
                n_py = ey + (eh >>> 1);
            end
        endcase
    end

    // point register with its sideband
    always_ff @(posedge i_clk) begin
        r_px       <= n_px;
        r_py       <= n_py;
        r_side.idx <= r_idx;
        r_side.tag <= r_tag;
        if (!i_rst_n) begin
            r_side.vld <= 1'b0;
        end else begin
            r_side.vld <= r_act;
        end
    end

    assign o_px   = r_px;
    assign o_py   = r_py;
    assign o_side = r_side;

endmodule

// ===== sv/drgc_cell_div.sv =====
// one axis: bounds test, scale by piece count, then a one-bit-per-stage divider
// depends on drgc_pkg
module drgc_cell_div #(
    parameter int COORD_BITS = drgc_pkg::COORD_D,
    parameter int CB         = 7
) (
    input  logic                          i_clk,
    input  logic signed [COORD_BITS:0]    i_p,
    input  logic [drgc_pkg::SIZE_W-1:0]   i_size,
    input  logic [CB-1:0]                 i_n,
    output logic                          o_ok,
    output logic [CB-1:0]                 o_cell
);

    localparam int SW = drgc_pkg::SIZE_W;
    localparam int PW = SW + CB;
    localparam int EW = (COORD_BITS + 1 > SW + 1) ? COORD_BITS + 1 : SW + 1;

    logic [PW-1:0]   r_rem [0:CB];
    logic [CB-1:0]   r_q   [0:CB];
    logic            r_ok  [0:CB];
    logic [SW-1:0]   div;
    logic signed [EW-1:0] pe, se;
    logic            ok;
    logic [CB:0]     q1;

    assign div = (i_size == '0) ? SW'(1) : i_size;
    assign pe  = EW'(i_p);
    assign se  = EW'($signed({1'b0, i_size}));
    assign ok  = (pe >= 0) && (pe <= se);

    // scale stage, the point is known to fit the size width once in range
    always_ff @(posedge i_clk) begin
        r_ok[0]  <= ok;
        r_q[0]   <= '0;
        r_rem[0] <= ok ? (PW'(pe[SW-1:0]) * PW'(i_n)) : '0;
    end

    // restoring divide, quotient bit CB-j in stage j
    for (genvar j = 1; j <= CB; j++) begin : g_stage
        logic [PW-1:0] dsh;
        assign dsh = PW'(div) << (CB - j);
        always_ff @(posedge i_clk) begin
            r_ok[j] <= r_ok[j-1];
            if (r_rem[j-1] >= dsh) begin
                r_rem[j] <= r_rem[j-1] - dsh;
                r_q[j]   <= r_q[j-1] | (CB'(1) << (CB - j));
            end else begin
                r_rem[j] <= r_rem[j-1];
                r_q[j]   <= r_q[j-1];
            end
        end
    end

    // one-based cell, clamped to the piece count
    assign q1     = {1'b0, r_q[CB]} + (CB+1)'(1);
    assign o_ok   = r_ok[CB];
    assign o_cell = (q1 > {1'b0, i_n}) ? i_n : q1[CB-1:0];

endmodule

// ===== sv/drgc_merge.sv =====
// drops repeated cells, sets the last flag and drives the result word
// depends on drgc_pkg
module drgc_merge #(
    parameter int CB = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  drgc_pkg::t_side             i_side,
    input  logic                        i_ok,
    input  logic [CB-1:0]               i_col,
    input  logic [CB-1:0]               i_row,
    output logic                        o_valid,
    output logic [CB-1:0]               o_col,
    output logic [CB-1:0]               o_row,
    output logic                        o_outside,
    output logic [drgc_pkg::TAG_W-1:0]  o_tag,
    output logic                        o_last
);

    localparam int SN = drgc_pkg::SEEN_N;
    localparam int NB = $clog2(SN + 1);

    logic [CB-1:0]  r_sc [0:SN-1];
    logic [CB-1:0]  r_sr [0:SN-1];
    logic [NB-1:0]  r_cnt, n_cnt;
    logic           r_pv, n_pv;
    logic [CB-1:0]  r_pc, r_pr, n_pc, n_pr;
    logic [drgc_pkg::TAG_W-1:0] r_ptag, n_ptag;
    logic           r_fv, n_fv;
    logic [CB-1:0]  r_fc, r_fr, n_fc, n_fr;
    logic [drgc_pkg::TAG_W-1:0] r_ftag, n_ftag;
    logic           r_ov, n_ov, r_oout, n_oout, r_olast, n_olast;
    logic [CB-1:0]  r_oc, r_or, n_oc, n_or;
    logic [drgc_pkg::TAG_W-1:0] r_otag, n_otag;
    logic           dup, fresh, store;

    // repeat check against cells already kept for this defect
    always_comb begin
        dup = 1'b0;
        for (int k = 0; k < SN; k++) begin
            if ((NB'(k) < r_cnt) && (r_sc[k] == i_col) && (r_sr[k] == i_row)) begin
                dup = 1'b1;
            end
        end
        if (i_side.idx == drgc_pkg::PT_TL) begin
            dup = 1'b0;
        end
        fresh = i_side.vld && i_ok && !dup;
    end

    // one-deep hold so the last flag is known before a cell leaves
    always_comb begin
        n_cnt = r_cnt;  n_pv = r_pv;  n_pc = r_pc;  n_pr = r_pr;  n_ptag = r_ptag;
        n_fv = 1'b0;    n_fc = r_fc;  n_fr = r_fr;  n_ftag = r_ftag;
        n_ov = 1'b0;    n_oc = r_oc;  n_or = r_or;  n_otag = r_otag;
        n_oout = 1'b0;  n_olast = 1'b0;
        store = 1'b0;
        if (r_fv) begin
            n_ov = 1'b1; n_oc = r_fc; n_or = r_fr; n_otag = r_ftag; n_olast = 1'b1;
        end
        if (i_side.vld) begin
            case (i_side.idx)
                drgc_pkg::PT_TL: begin
                    n_pv = fresh; n_pc = i_col; n_pr = i_row; n_ptag = i_side.tag;
                    n_cnt = NB'(fresh);
                    store = fresh;
                end
                drgc_pkg::PT_MID: begin
                    n_pv = 1'b0;
                    n_ov = 1'b1;
                    n_otag = i_side.tag;
                    if (fresh && r_pv) begin
                        n_oc = r_pc; n_or = r_pr;
                        n_fv = 1'b1; n_fc = i_col; n_fr = i_row; n_ftag = i_side.tag;
                    end else if (fresh) begin
                        n_oc = i_col; n_or = i_row; n_olast = 1'b1;
                    end else if (r_pv) begin
                        n_oc = r_pc; n_or = r_pr; n_olast = 1'b1;
                    end else begin
                        n_oc = '0; n_or = '0; n_oout = 1'b1; n_olast = 1'b1;
                    end
                end
                default: begin
                    if (fresh) begin
                        if (r_pv) begin
                            n_ov = 1'b1; n_oc = r_pc; n_or = r_pr; n_otag = r_ptag;
                        end
                        n_pv = 1'b1; n_pc = i_col; n_pr = i_row; n_ptag = i_side.tag;
                        n_cnt = r_cnt + NB'(1);
                        store = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_pv  <= 1'b0;
            r_fv  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_pv  <= n_pv;
            r_fv  <= n_fv;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pc <= n_pc;  r_pr <= n_pr;  r_ptag <= n_ptag;
        r_fc <= n_fc;  r_fr <= n_fr;  r_ftag <= n_ftag;
        r_oc <= n_oc;  r_or <= n_or;  r_otag <= n_otag;
        r_oout <= n_oout;
        r_olast <= n_olast;
        if (store) begin
            if (i_side.idx == drgc_pkg::PT_TL) begin
                r_sc[0] <= i_col;
                r_sr[0] <= i_row;
            end else begin
                r_sc[r_cnt[NB-2:0]] <= i_col;
                r_sr[r_cnt[NB-2:0]] <= i_row;
            end
        end
    end

    assign o_valid   = r_ov;
    assign o_col     = r_oc;
    assign o_row     = r_or;
    assign o_outside = r_oout;
    assign o_tag     = r_otag;
    assign o_last    = r_olast;

endmodule

// ===== sv/defect_rect_to_grid_cells.sv =====
// top level: config registers, point sequencer, divider pair, result merge
// depends on drgc_pkg, drgc_point_gen, drgc_cell_div, drgc_merge
//
// A defect is taken when start is high and busy is low; the point
// sequencer then feeds its five tested points to the shared column/row
// divider pair one point per cycle, and can take the next defect while
// it forms the last point. Results leave one per cycle on o_valid,
// 1 to 5 per defect in point order, and cannot be held off.
// CB is the bit count of MAX_CELLS, 7 at 64.
module defect_rect_to_grid_cells #(
    parameter int MAX_CELLS  = drgc_pkg::MAX_CELLS_D,
    parameter int COORD_BITS = drgc_pkg::COORD_D,
    parameter int CB         = $clog2(MAX_CELLS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_BITS-1:0]  i_rect_x,
    input  logic signed [COORD_BITS-1:0]  i_rect_y,
    input  logic signed [COORD_BITS-1:0]  i_rect_w,
    input  logic signed [COORD_BITS-1:0]  i_rect_h,
    input  logic [drgc_pkg::TAG_W-1:0]    i_defect_tag,
    output logic                          o_valid,
    output logic [CB-1:0]                 o_cell_col,
    output logic [CB-1:0]                 o_cell_row,
    output logic                          o_outside,
    output logic [drgc_pkg::TAG_W-1:0]    o_tag_out,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int SW = drgc_pkg::SIZE_W;
    localparam int NW = drgc_pkg::COUNT_W;
    localparam int LAT = CB + 1;
    localparam int EW = (NW > CB) ? NW : CB;

    logic [SW-1:0] r_sw, r_sh;
    logic [NW-1:0] r_cols, r_rows;
    logic [CB-1:0] nc, nr;
    drgc_pkg::t_reg ra;
    logic signed [COORD_BITS:0] px, py;
    drgc_pkg::t_side side, r_side [0:LAT-1];
    logic ok_c, ok_r;
    logic [CB-1:0] col, row;

    // config registers
    assign pready = 1'b1;
    assign ra = drgc_pkg::t_reg'(paddr[3:2]);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw   <= drgc_pkg::SIZE_RESET;
            r_sh   <= drgc_pkg::SIZE_RESET;
            r_cols <= drgc_pkg::COUNT_RESET;
            r_rows <= drgc_pkg::COUNT_RESET;
        end else if (psel && penable && pwrite) begin
            case (ra)
                drgc_pkg::REG_SURF_W: r_sw   <= pwdata[SW-1:0];
                drgc_pkg::REG_SURF_H: r_sh   <= pwdata[SW-1:0];
                drgc_pkg::REG_COLS:   r_cols <= pwdata[NW-1:0];
                default:              r_rows <= pwdata[NW-1:0];
            endcase
        end
    end

    always_comb begin
        case (ra)
            drgc_pkg::REG_SURF_W: prdata = 32'(r_sw);
            drgc_pkg::REG_SURF_H: prdata = 32'(r_sh);
            drgc_pkg::REG_COLS:   prdata = 32'(r_cols);
            default:              prdata = 32'(r_rows);
        endcase
    end

    // piece counts: zero counts as one, saturate at the maximum
    function automatic logic [CB-1:0] eff_count(input logic [NW-1:0] n);
        logic [EW-1:0] v;
        v = EW'(n);
        if (v == '0) return CB'(1);
        if (v > EW'(MAX_CELLS)) return CB'(MAX_CELLS);
        return CB'(v);
    endfunction

    assign nc = eff_count(r_cols);
    assign nr = eff_count(r_rows);

    drgc_point_gen #(.COORD_BITS(COORD_BITS)) u_pts (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_x(i_rect_x), .i_y(i_rect_y), .i_w(i_rect_w), .i_h(i_rect_h),
        .i_tag(i_defect_tag), .o_busy(busy),
        .o_px(px), .o_py(py), .o_side(side)
    );

    drgc_cell_div #(.COORD_BITS(COORD_BITS), .CB(CB)) u_div_col (
        .i_clk(i_clk), .i_p(px), .i_size(r_sw), .i_n(nc),
        .o_ok(ok_c), .o_cell(col)
    );

    drgc_cell_div #(.COORD_BITS(COORD_BITS), .CB(CB)) u_div_row (
        .i_clk(i_clk), .i_p(py), .i_size(r_sh), .i_n(nr),
        .o_ok(ok_r), .o_cell(row)
    );

    // sideband delay matching the divider depth
    always_ff @(posedge i_clk) begin
        r_side[0].idx <= side.idx;
        r_side[0].tag <= side.tag;
        for (int k = 1; k < LAT; k++) begin
            r_side[k].idx <= r_side[k-1].idx;
            r_side[k].tag <= r_side[k-1].tag;
        end
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_side[k].vld <= 1'b0;
        end else begin
            r_side[0].vld <= side.vld;
            for (int k = 1; k < LAT; k++) r_side[k].vld <= r_side[k-1].vld;
        end
    end

    drgc_merge #(.CB(CB)) u_merge (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_side(r_side[LAT-1]),
        .i_ok(ok_c && ok_r), .i_col(col), .i_row(row),
        .o_valid(o_valid), .o_col(o_cell_col), .o_row(o_cell_row),
        .o_outside(o_outside), .o_tag(o_tag_out), .o_last(o_last)
    );

endmodule

// ===== sv/drgc_checker.sv =====
// port-level checks on the defect rectangle to grid cell block
// depends on defect_rect_to_grid_cells ports, attached by bind
module drgc_checker #(
    parameter int CB = 7
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_valid,
    input logic [CB-1:0] o_cell_col,
    input logic [CB-1:0] o_cell_row,
    input logic          o_outside,
    input logic          o_last
);

    // a taken defect keeps the block busy for its next point
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy low after start");

    // an outside word is the only word of its defect and has no cell
    a_outside_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_outside) |-> (o_last && o_cell_col == '0 && o_cell_row == '0))
        else $error("bad outside word");

    // a cell word has one-based indices
    a_cell_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_outside) |-> (o_cell_col != '0 && o_cell_row != '0))
        else $error("zero cell index");

endmodule

bind defect_rect_to_grid_cells drgc_checker #(.CB(CB)) u_drgc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_cell_col(o_cell_col), .o_cell_row(o_cell_row),
    .o_outside(o_outside), .o_last(o_last)
);

// ===== test/tb_defect_rect_to_grid_cells.sv =====
// testbench for defect_rect_to_grid_cells: drives defects and register writes,
// predicts the grid cells of each defect and checks every result word
// depends on drgc_pkg and defect_rect_to_grid_cells
`timescale 1ns / 100ps

// expected cell words and their comparison
class cell_scoreboard;
    typedef struct {
        logic [6:0]  col;
        logic [6:0]  row;
        logic        outside;
        logic [15:0] tag;
        logic        last;
    } t_cell_word;

    t_cell_word pending_cells[$];
    int         mismatches;
    int         words_checked;
    int         outside_seen;
    int         multi_seen;

    logic [22:0] surf_w;
    logic [22:0] surf_h;
    logic [6:0]  cols;
    logic [6:0]  rows;

    function new();
        surf_w = drgc_pkg::SIZE_RESET;
        surf_h = drgc_pkg::SIZE_RESET;
        cols = drgc_pkg::COUNT_RESET;
        rows = drgc_pkg::COUNT_RESET;
        mismatches = 0;
        words_checked = 0;
        outside_seen = 0;
        multi_seen = 0;
    endfunction

    function void set_reg(drgc_pkg::t_reg idx, logic [31:0] val);
        case (idx)
            drgc_pkg::REG_SURF_W: surf_w = val[22:0];
            drgc_pkg::REG_SURF_H: surf_h = val[22:0];
            drgc_pkg::REG_COLS:   cols = val[6:0];
            drgc_pkg::REG_ROWS:   rows = val[6:0];
            default: ;
        endcase
    endfunction

    static function longint piece_count(logic [6:0] n);
        if (n == 0) return 1;
        if (n > drgc_pkg::MAX_CELLS_D) return drgc_pkg::MAX_CELLS_D;
        return n;
    endfunction

    static function longint cell_index(longint p, logic [22:0] size, longint n);
        longint dv;
        longint q;
        dv = (size == 0) ? 1 : longint'(size);
        q = (p * n) / dv + 1;
        return (q > n) ? n : q;
    endfunction

    // note an accepted defect and queue the cells it touches
    function void note_defect(logic signed [23:0] x, logic signed [23:0] y,
                              logic signed [23:0] w, logic signed [23:0] h,
                              logic [15:0] tag);
        longint px[5];
        longint py[5];
        longint cc[5];
        longint cr[5];
        longint nc;
        longint nr;
        longint c;
        longint r;
        int     cnt;
        bit     dup;
        t_cell_word wd;
        nc = piece_count(cols);
        nr = piece_count(rows);
        cnt = 0;
        px[0] = x;          py[0] = y;
        px[1] = x + w;      py[1] = y;
        px[2] = x;          py[2] = y + h;
        px[3] = x + w;      py[3] = y + h;
        px[4] = x + (w >>> 1); py[4] = y + (h >>> 1);
        for (int i = 0; i < 5; i++) begin
            if (px[i] < 0 || px[i] > longint'(surf_w) || py[i] < 0 ||
                py[i] > longint'(surf_h))
                continue;
            c = cell_index(px[i], surf_w, nc);
            r = cell_index(py[i], surf_h, nr);
            dup = 0;
            for (int k = 0; k < cnt; k++)
                if (cc[k] == c && cr[k] == r) dup = 1;
            if (!dup) begin
                cc[cnt] = c;
                cr[cnt] = r;
                cnt++;
            end
        end
        if (cnt == 0) begin
            wd = '{7'd0, 7'd0, 1'b1, tag, 1'b1};
            pending_cells.push_back(wd);
            return;
        end
        for (int k = 0; k < cnt; k++) begin
            wd = '{cc[k][6:0], cr[k][6:0], 1'b0, tag, (k == cnt - 1)};
            pending_cells.push_back(wd);
        end
    endfunction

    // compare one result word with the oldest expectation
    function void check_word(logic [6:0] col, logic [6:0] row, logic outside,
                             logic [15:0] tag, logic last);
        t_cell_word e;
        words_checked++;
        if (pending_cells.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word col=%0d row=%0d out=%0b tag=%h last=%0b",
                         col, row, outside, tag, last);
            return;
        end
        e = pending_cells.pop_front();
        if (outside) outside_seen++;
        if (!last) multi_seen++;
        if (e.col !== col || e.row !== row || e.outside !== outside ||
            e.tag !== tag || e.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch exp col=%0d row=%0d out=%0b tag=%h last=%0b",
                          " / got col=%0d row=%0d out=%0b tag=%h last=%0b"},
                         e.col, e.row, e.outside, e.tag, e.last,
                         col, row, outside, tag, last);
        end
    endfunction
endclass

module tb_defect_rect_to_grid_cells;

    localparam int STALL_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic signed [23:0] i_rect_x = '0;
    logic signed [23:0] i_rect_y = '0;
    logic signed [23:0] i_rect_w = '0;
    logic signed [23:0] i_rect_h = '0;
    logic [15:0] i_defect_tag = '0;
    logic        o_valid;
    logic [6:0]  o_cell_col;
    logic [6:0]  o_cell_row;
    logic        o_outside;
    logic [15:0] o_tag_out;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    cell_scoreboard sb;
    int   idle_pct;
    int   defects_sent;
    int   idle_count = 0;
    logic timed_out = 1'b0;

    defect_rect_to_grid_cells dut (.*);

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result check on each strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_word(o_cell_col, o_cell_row, o_outside, o_tag_out, o_last);
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (psel && penable))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(drgc_pkg::t_reg idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic set_grid(logic [31:0] sw, logic [31:0] sh,
                            logic [31:0] nc, logic [31:0] nr);
        write_reg(drgc_pkg::REG_SURF_W, sw);
        write_reg(drgc_pkg::REG_SURF_H, sh);
        write_reg(drgc_pkg::REG_COLS, nc);
        write_reg(drgc_pkg::REG_ROWS, nr);
    endtask

    // wait until every expected word has come, then let the pipe drain
    task automatic drain();
        start <= 1'b0;
        while (sb.pending_cells.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_defect(logic signed [23:0] x, logic signed [23:0] y,
                               logic signed [23:0] w, logic signed [23:0] h,
                               logic [15:0] tag);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_rect_x <= x;
        i_rect_y <= y;
        i_rect_w <= w;
        i_rect_h <= h;
        i_defect_tag <= tag;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_defect(x, y, w, h, tag);
        defects_sent++;
    endtask

    // random defect, mostly placed near or on the surface
    task automatic send_random();
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] w;
        logic signed [23:0] h;
        int mode;
        mode = $urandom_range(9);
        if (mode < 7) begin
            x = 24'($signed(24'($urandom_range(sb.surf_w + 40))) - 20);
            y = 24'($signed(24'($urandom_range(sb.surf_h + 40))) - 20);
            w = 24'($signed(24'($urandom_range(sb.surf_w / 2 + 10))) - 5);
            h = 24'($signed(24'($urandom_range(sb.surf_h / 2 + 10))) - 5);
            if ($urandom_range(4) == 0) w = -w;
            if ($urandom_range(4) == 0) h = -h;
        end else begin
            x = 24'($urandom);
            y = 24'($urandom);
            w = 24'($urandom);
            h = 24'($urandom);
        end
        send_defect(x, y, w, h, 16'($urandom));
    endtask

    initial begin
        sb = new();
        idle_pct = 36;
        defects_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset grid, extremes, negative sizes, odd halves
        send_defect(24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'h0000);
        send_defect(24'sd16000, 24'sd16000, 24'sd0, 24'sd0, 16'hffff);
        send_defect(-24'sd8388608, -24'sd8388608, -24'sd8388608, -24'sd8388608,
                    16'h1234);
        send_defect(24'sd8388607, 24'sd8388607, 24'sd8388607, 24'sd8388607, 16'h8001);
        drain();
        set_grid(32'd1000, 32'd600, 32'd10, 32'd6);
        send_defect(24'sd50, 24'sd50, 24'sd900, 24'sd500, 16'h0101);
        send_defect(24'sd990, 24'sd590, 24'sd20, 24'sd20, 16'h0102);
        send_defect(24'sd500, 24'sd300, -24'sd7, -24'sd3, 16'h0103);
        send_defect(-24'sd5, 24'sd100, 24'sd11, 24'sd0, 16'h0104);
        send_defect(24'sd120, 24'sd130, 24'sd1, 24'sd1, 16'h0105);
        send_defect(24'sd1000, 24'sd600, 24'sd0, 24'sd0, 16'h0106);
        send_defect(24'sd1001, 24'sd0, 24'sd5, 24'sd5, 16'h0107);
        drain();
        // zero sizes and zero counts, then oversize counts
        set_grid(32'd0, 32'd0, 32'd0, 32'd0);
        send_defect(24'sd0, 24'sd0, 24'sd1, 24'sd1, 16'h0201);
        send_defect(24'sd1, 24'sd0, -24'sd1, 24'sd0, 16'h0202);
        drain();
        set_grid(32'h7fffff, 32'h7fffff, 32'h7f, 32'd64);
        send_defect(24'sd0, 24'sd0, 24'sd8388607, 24'sd8388607, 16'h0301);
        send_defect(24'sd4194303, 24'sd131072, 24'sd3, 24'sd65537, 16'h0302);
        send_defect(24'sd8388607, 24'sd0, -24'sd8388608, 24'sd0, 16'h0303);
        drain();

        // random phases over several grids and idle patterns
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 3)
                0: set_grid($urandom_range(1, 4000), $urandom_range(1, 4000),
                            $urandom_range(1, 64), $urandom_range(1, 64));
                1: set_grid($urandom_range(1, 200), $urandom_range(1, 200),
                            $urandom_range(0, 127), $urandom_range(0, 127));
                default: set_grid($urandom_range(1, 32'h7fffff),
                                  $urandom_range(1, 32'h7fffff), 64, 1);
            endcase
            idle_pct = (ph < 2) ? 36 : (ph < 4) ? 45 : 0;
            for (int n = 0; n < 45; n++) send_random();
            drain();
        end

        $display("defects sent %0d, words checked %0d, outside %0d, non-final %0d",
                 defects_sent, sb.words_checked, sb.outside_seen, sb.multi_seen);
        if (sb.mismatches == 0 && sb.pending_cells.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
